### sv/pvh_pkg.sv
// pvh_pkg: shared widths, register indexes and the controller-to-datapath command word
// used by every file of the pi_velocity_hbridge_pwm block; depends on nothing
`default_nettype none

package pvh_pkg;

    localparam int SpeedW   = 16;
    localparam int MeasW    = 15;
    localparam int DutyW    = 17;
    localparam int ErrW     = 17;
    localparam int IntW     = 32;
    localparam int GainW    = 16;
    localparam int BitsW    = 5;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 17;

    // register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_P_GAIN   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_I_GAIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_DUTY = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PWM_BITS = 2'd3;

    localparam logic [BitsW-1:0] PWM_BITS_RST = 5'd8;
    localparam logic [BitsW-1:0] PWM_BITS_MIN = 5'd1;
    localparam logic [BitsW-1:0] PWM_BITS_MAX = 5'd16;

    // +1.0 in Q1.16
    localparam logic [DutyW-1:0] DRIVE_ONE = 17'h10000;

    typedef struct packed {
        logic load_in;   // capture word, form error and integrator
        logic mul;       // gain products, duty span
        logic drive;     // pi sum, clamp, magnitude
        logic emit;      // duty, direction, result register
    } pvh_cmd_t;

endpackage

`default_nettype wire

### sv/pvh_in_if.sv
// pvh_in_if: input channel carrying one control tick (target and measured speed)
// depends on pvh_pkg for field widths
`default_nettype none

interface pvh_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pvh_pkg::SpeedW-1:0] target_speed;
    logic        [pvh_pkg::MeasW-1:0]  measured_speed_abs;

    modport source (output valid, output target_speed, output measured_speed_abs,
                    input ready);
    modport sink   (input valid, input target_speed, input measured_speed_abs,
                    output ready);
endinterface

`default_nettype wire

### sv/pvh_out_if.sv
// pvh_out_if: result channel carrying bridge duties, direction and error
// depends on pvh_pkg for field widths
`default_nettype none

interface pvh_out_if;
    logic                            valid;
    logic                            ready;
    logic        [pvh_pkg::DutyW-1:0] duty_forward;
    logic        [pvh_pkg::DutyW-1:0] duty_reverse;
    logic                             moving_forward;
    logic signed [pvh_pkg::ErrW-1:0]  speed_error;
    logic        [pvh_pkg::DutyW-1:0] duty_level;

    modport source (output valid, output duty_forward, output duty_reverse,
                    output moving_forward, output speed_error, output duty_level,
                    input ready);
    modport sink   (input valid, input duty_forward, input duty_reverse,
                    input moving_forward, input speed_error, input duty_level,
                    output ready);
endinterface

`default_nettype wire

### sv/pvh_cfg_if.sv
// pvh_cfg_if: register write channel (index and data)
// depends on pvh_pkg for field widths
`default_nettype none

interface pvh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pvh_pkg::CfgIdxW-1:0]     index;
    logic [pvh_pkg::CfgDataW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/pvh_ctrl.sv
// pvh_ctrl: sequencer that steps one word through the datapath and owns the handshakes
// depends on pvh_pkg for the command struct
`default_nettype none

module pvh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pvh_pkg::pvh_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DRV  = 2'd2;
    localparam logic [1:0] ST_DUTY = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_space;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_space = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRV;
            end
            ST_DRV:
            begin
                cmd.drive  = 1'b1;
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                // hold until the result register is free
                if (out_space)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/pvh_datapath.sv
// pvh_datapath: config registers, integrator, gain products, clamp, duty scaling, result register
// depends on pvh_pkg; driven by pvh_ctrl through pvh_cmd_t
`default_nettype none

module pvh_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pvh_pkg::pvh_cmd_t                 cmd,
    input  wire logic                              cfg_we,
    input  wire logic [pvh_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [pvh_pkg::CfgDataW-1:0]      cfg_data,
    input  wire logic signed [pvh_pkg::SpeedW-1:0] target_speed,
    input  wire logic [pvh_pkg::MeasW-1:0]         measured_speed_abs,
    output logic [pvh_pkg::DutyW-1:0]              duty_forward,
    output logic [pvh_pkg::DutyW-1:0]              duty_reverse,
    output logic                                   moving_forward,
    output logic signed [pvh_pkg::ErrW-1:0]        speed_error,
    output logic [pvh_pkg::DutyW-1:0]              duty_level
);

    localparam int DW = pvh_pkg::DutyW;
    localparam int EW = pvh_pkg::ErrW;
    localparam int IW = pvh_pkg::IntW;
    localparam int GW = pvh_pkg::GainW;
    localparam int PPW = EW + GW + 1;      // error x gain
    localparam int PIW = IW + GW + 1;      // integral x gain
    localparam int SW  = PIW + 1;          // pi sum
    localparam int MW  = 2 * DW;           // span x magnitude

    // configuration
    logic [GW-1:0]               p_gain_reg, i_gain_reg;
    logic [DW-1:0]               offset_reg;
    logic [pvh_pkg::BitsW-1:0]   pwm_bits_reg;

    // state
    logic signed [IW-1:0]        integral_reg, integral_next;
    logic                        dir_reg, dir_next;

    // working registers
    logic signed [EW-1:0]        err_reg, err_next;
    logic signed [PPW-1:0]       prod_p_reg, prod_p_next;
    logic signed [PIW-1:0]       prod_i_reg, prod_i_next;
    logic [DW-1:0]               span_reg, span_next;
    logic [DW-1:0]               offs_reg, offs_next;
    logic [DW-1:0]               mag_reg, mag_next;
    logic                        pos_reg, pos_next;
    logic                        neg_reg, neg_next;

    // result register
    logic [DW-1:0]               fwd_reg, rev_reg, level_reg, duty_next;
    logic                        mov_reg;
    logic signed [EW-1:0]        serr_reg;

    logic signed [EW-1:0]        meas_signed;
    logic signed [IW:0]          sum_wide;
    logic [pvh_pkg::BitsW-1:0]   bits_eff;
    logic [DW-1:0]               full_scale;
    logic signed [SW-1:0]        drive_sum, drive_neg;
    logic [MW-1:0]               scaled;

    // error and saturating integrator
    always_comb
    begin
        meas_signed = dir_reg ? $signed({2'b00, measured_speed_abs})
                              : -$signed({2'b00, measured_speed_abs});
        err_next = $signed({target_speed[pvh_pkg::SpeedW-1], target_speed}) - meas_signed;
        sum_wide = $signed({integral_reg[IW-1], integral_reg})
                 + $signed({{(IW+1-EW){err_next[EW-1]}}, err_next});
        if (sum_wide[IW] != sum_wide[IW-1])
            integral_next = sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        else
            integral_next = sum_wide[IW-1:0];
    end

    // gain products and effective pwm span
    always_comb
    begin
        prod_p_next = err_reg * $signed({1'b0, p_gain_reg});
        prod_i_next = integral_reg * $signed({1'b0, i_gain_reg});
        if (pwm_bits_reg < pvh_pkg::PWM_BITS_MIN)
            bits_eff = pvh_pkg::PWM_BITS_MIN;
        else if (pwm_bits_reg > pvh_pkg::PWM_BITS_MAX)
            bits_eff = pvh_pkg::PWM_BITS_MAX;
        else
            bits_eff = pwm_bits_reg;
        full_scale = DW'(1) << bits_eff;
        offs_next  = (offset_reg > full_scale) ? full_scale : offset_reg;
        span_next  = full_scale - offs_next;
    end

    // pi sum, clamp to +-1.0, magnitude
    always_comb
    begin
        drive_sum = $signed({{(SW-PPW){prod_p_reg[PPW-1]}}, prod_p_reg})
                  + $signed({prod_i_reg[PIW-1], prod_i_reg});
        drive_neg = -drive_sum;
        pos_next  = !drive_sum[SW-1] && (drive_sum != '0);
        neg_next  = drive_sum[SW-1];
        if (drive_sum > $signed({{(SW-DW){1'b0}}, pvh_pkg::DRIVE_ONE}))
            mag_next = pvh_pkg::DRIVE_ONE;
        else if (drive_neg > $signed({{(SW-DW){1'b0}}, pvh_pkg::DRIVE_ONE}))
            mag_next = pvh_pkg::DRIVE_ONE;
        else if (neg_next)
            mag_next = drive_neg[DW-1:0];
        else
            mag_next = drive_sum[DW-1:0];
    end

    // duty and direction
    always_comb
    begin
        scaled    = span_reg * mag_reg;
        duty_next = offs_reg + scaled[DW+15:16];
        if (pos_reg)
            dir_next = 1'b1;
        else if (neg_reg)
            dir_next = 1'b0;
        else
            dir_next = dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg   <= '0;
            i_gain_reg   <= '0;
            offset_reg   <= '0;
            pwm_bits_reg <= pvh_pkg::PWM_BITS_RST;
            integral_reg <= '0;
            dir_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pvh_pkg::REG_P_GAIN:   p_gain_reg   <= cfg_data[GW-1:0];
                    pvh_pkg::REG_I_GAIN:   i_gain_reg   <= cfg_data[GW-1:0];
                    pvh_pkg::REG_MIN_DUTY: offset_reg   <= cfg_data[DW-1:0];
                    pvh_pkg::REG_PWM_BITS: pwm_bits_reg <= cfg_data[pvh_pkg::BitsW-1:0];
                    default:               p_gain_reg   <= p_gain_reg;
                endcase
            end
            if (cmd.load_in)
                integral_reg <= integral_next;
            if (cmd.emit)
                dir_reg <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            err_reg <= err_next;
        if (cmd.mul)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            offs_reg   <= offs_next;
            span_reg   <= span_next;
        end
        if (cmd.drive)
        begin
            mag_reg <= mag_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
        if (cmd.emit)
        begin
            fwd_reg   <= pos_reg ? duty_next : '0;
            rev_reg   <= neg_reg ? duty_next : '0;
            level_reg <= duty_next;
            mov_reg   <= dir_next;
            serr_reg  <= err_reg;
        end
    end

    assign duty_forward   = fwd_reg;
    assign duty_reverse   = rev_reg;
    assign duty_level     = level_reg;
    assign moving_forward = mov_reg;
    assign speed_error    = serr_reg;

endmodule

`default_nettype wire

### sv/pi_velocity_hbridge_pwm.sv
// pi_velocity_hbridge_pwm: top level of the pi speed controller with h-bridge pwm duties
// depends on pvh_pkg, pvh_in_if, pvh_out_if, pvh_cfg_if, pvh_ctrl, pvh_datapath
//
//  channel  | dir | fields                                       | accepted when
//  ---------+-----+----------------------------------------------+---------------
//  in_ch    | in  | target_speed, measured_speed_abs             | valid && ready
//  out_ch   | out | duty_forward, duty_reverse, moving_forward,  | valid && ready
//           |     | speed_error, duty_level                      |
//  cfg_ch   | in  | index (p_gain, i_gain, min_duty, pwm_bits),  | valid && ready
//           |     | data                                         |
//
//  one word passes four steps: accept (error and integrator), gain products,
//  pi sum and clamp, duty scaling into the result register
//  the fixed four-step sequencer runs them in that order; a new word is taken once
//  the previous one has reached the result register
//  a stalled result holds the last step until the result register frees up
//  reset clears the integrator, sets direction forward and loads register defaults
//  the config channel is always ready
`default_nettype none

module pi_velocity_hbridge_pwm (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pvh_in_if.sink     in_ch,
    pvh_out_if.source  out_ch,
    pvh_cfg_if.sink    cfg_ch
);

    pvh_pkg::pvh_cmd_t cmd;
    logic              cfg_we;

    // register writes land whenever presented
    assign cfg_ch.ready = 1'b1;
    assign cfg_we       = cfg_ch.valid;

    // sequencer: input/output handshakes and step commands
    pvh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // arithmetic, state and the result register
    pvh_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_ch.index),
        .cfg_data           (cfg_ch.data),
        .target_speed       (in_ch.target_speed),
        .measured_speed_abs (in_ch.measured_speed_abs),
        .duty_forward       (out_ch.duty_forward),
        .duty_reverse       (out_ch.duty_reverse),
        .moving_forward     (out_ch.moving_forward),
        .speed_error        (out_ch.speed_error),
        .duty_level         (out_ch.duty_level)
    );

endmodule

`default_nettype wire

### sv/pvh_checker.sv
// pvh_checker: port-level assertions for pi_velocity_hbridge_pwm, bound to the top level
// depends on pvh_pkg for field widths
`default_nettype none

module pvh_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [pvh_pkg::DutyW-1:0]         duty_forward,
    input wire logic [pvh_pkg::DutyW-1:0]         duty_reverse,
    input wire logic                              moving_forward,
    input wire logic signed [pvh_pkg::ErrW-1:0]   speed_error,
    input wire logic [pvh_pkg::DutyW-1:0]         duty_level
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_forward)
            && $stable(duty_reverse) && $stable(moving_forward)
            && $stable(speed_error) && $stable(duty_level))
        else $error("result word changed while stalled");

    // one word in flight: input closes after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in flight");

    // a new result appears only at the end of a word's steps
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2))
        else $error("result appeared too early");

    // at most one bridge leg driven
    a_one_leg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_forward == '0 || duty_reverse == '0)
        else $error("both bridge legs driven");

    // driven leg agrees with direction
    a_dir_leg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_forward == '0 || moving_forward)
            && (duty_reverse == '0 || !moving_forward))
        else $error("direction disagrees with driven leg");

endmodule

bind pi_velocity_hbridge_pwm pvh_checker u_pvh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .duty_forward   (out_ch.duty_forward),
    .duty_reverse   (out_ch.duty_reverse),
    .moving_forward (out_ch.moving_forward),
    .speed_error    (out_ch.speed_error),
    .duty_level     (out_ch.duty_level)
);

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for pi_velocity_hbridge_pwm, with a directed table and random ticks
// under random register settings, sender gaps and result stalls
// depends on pvh_pkg, the pvh_in_if, pvh_out_if and pvh_cfg_if interfaces and the block rtl
`default_nettype none

module tb;

    localparam int SpeedW   = pvh_pkg::SpeedW;
    localparam int MeasW    = pvh_pkg::MeasW;
    localparam int DutyW    = pvh_pkg::DutyW;
    localparam int ErrW     = pvh_pkg::ErrW;
    localparam int GainW    = pvh_pkg::GainW;
    localparam int BitsW    = pvh_pkg::BitsW;
    localparam int CfgIdxW  = pvh_pkg::CfgIdxW;
    localparam int CfgDataW = pvh_pkg::CfgDataW;

    // expected contents of one result word
    typedef struct packed {
        logic [DutyW-1:0]        fwd;
        logic [DutyW-1:0]        rev;
        logic                    dir;
        logic signed [ErrW-1:0]  err;
        logic [DutyW-1:0]        level;
    } bridge_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,        // register write, block drained first
        ROW_TICK,       // tick checked against the predictor
        ROW_TICK_CHK    // tick with its result typed in below
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CfgIdxW-1:0]      reg_idx;    // ignored by tick rows
        logic [CfgDataW-1:0]     reg_data;
        logic signed [SpeedW-1:0] tgt;
        logic [MeasW-1:0]        meas;
        bridge_result_t          want;
    } stim_row_t;

    localparam longint IntTop      = 64'sd2147483647;
    localparam longint IntBottom   = -64'sd2147483648;
    localparam int     SettleCycles = 8;
    localparam int     RandomTicks  = 1750;
    localparam int     NumRows      = 35;

    // directed part: extremes of both fields, clamping both ways, zero drive,
    // measurement sign flipped by a reverse heading, pwm resolution below and
    // above its range, offset above full scale and offset equal to full scale
    localparam stim_row_t DirectedRows [NumRows] = '{
        // reset state: no gains, offset 0, 8-bit pwm, heading forward
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd0,
          '{17'd0, 17'd0, 1'b1, 17'sd0, 17'd0}},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd32767, 15'd32767,
          '{17'd0, 17'd0, 1'b1, 17'sd0, 17'd0}},
        // most negative error
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sh8000, 15'd32767,
          '{17'd0, 17'd0, 1'b1, -17'sd65535, 17'd0}},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd32767, 15'd0,
          '{17'd0, 17'd0, 1'b1, 17'sd32767, 17'd0}},
        '{ROW_CFG, pvh_pkg::REG_MIN_DUTY, 17'd5, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd65535, 16'sd0, 15'd0, '0},
        // drive clamped to +1.0, then to -1.0 which flips the heading
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd32767, 15'd0,
          '{17'd256, 17'd0, 1'b1, 17'sd32767, 17'd256}},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sh8000, 15'd0,
          '{17'd0, 17'd256, 1'b0, -17'sd32768, 17'd256}},
        // reverse heading negates the measured speed
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd32767,
          '{17'd256, 17'd0, 1'b1, 17'sd32767, 17'd256}},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd0, '0},
        // zero drive: both legs off, level is the offset
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd100, 15'd40,
          '{17'd0, 17'd0, 1'b1, 17'sd60, 17'd5}},
        // resolution 0 acts as 1, offset saturates to full scale
        '{ROW_CFG, pvh_pkg::REG_PWM_BITS, 17'd0, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_MIN_DUTY, 17'd65536, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd1, 16'sd0, 15'd0, '0},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd1, 15'd0,
          '{17'd2, 17'd0, 1'b1, 17'sd1, 17'd2}},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd0,
          '{17'd0, 17'd0, 1'b1, 17'sd0, 17'd2}},
        // resolution 31 acts as 16
        '{ROW_CFG, pvh_pkg::REG_PWM_BITS, 17'd31, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_MIN_DUTY, 17'd0, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd65535, 16'sd0, 15'd0, '0},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, -16'sd1, 15'd0,
          '{17'd0, 17'd65535, 1'b0, -17'sd1, 17'd65535}},
        // largest positive error, full-scale duty
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd32767, 15'd32767,
          '{17'd65536, 17'd0, 1'b1, 17'sd65534, 17'd65536}},
        // offset equal to full scale, integral term alone drives
        '{ROW_CFG, pvh_pkg::REG_PWM_BITS, 17'd16, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_I_GAIN, 17'd65535, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_MIN_DUTY, 17'd65536, 16'sd0, 15'd0, '0},
        '{ROW_TICK_CHK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd0,
          '{17'd65536, 17'd0, 1'b1, 17'sd0, 17'd65536}},
        // moderate gains, left to the predictor
        '{ROW_CFG, pvh_pkg::REG_MIN_DUTY, 17'd1000, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_I_GAIN, 17'd1, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_P_GAIN, 17'd3, 16'sd0, 15'd0, '0},
        '{ROW_CFG, pvh_pkg::REG_PWM_BITS, 17'd12, 16'sd0, 15'd0, '0},
        '{ROW_TICK, pvh_pkg::REG_P_GAIN, 17'd0, -16'sd500, 15'd200, '0},
        '{ROW_TICK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd1234, 15'd4000, '0},
        '{ROW_TICK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sh8000, 15'd0, '0},
        '{ROW_TICK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd0, 15'd32767, '0},
        '{ROW_TICK, pvh_pkg::REG_P_GAIN, 17'd0, 16'sd5, 15'd5, '0}
    };

    logic clk;
    logic rst_n;

    pvh_in_if  in_ch ();
    pvh_out_if out_ch ();
    pvh_cfg_if cfg_ch ();

    pi_velocity_hbridge_pwm dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // predictor copy of the registers and of the controller state
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [DutyW-1:0] offset_reg;
    logic [BitsW-1:0] pwm_res;
    longint           integ_acc;
    bit               heading_fwd;

    bridge_result_t pending_duties [$];  // duties and error still owed by the block
    int             mismatch_count;
    bit             sender_gaps;         // idle cycles between input words
    bit             sink_stalls;         // ready held low after each result word
    int             stall_left;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard limit, well above the slowest legal run
    initial begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

    // one control tick through the predictor; updates integrator and heading
    task automatic predict_bridge(input logic signed [SpeedW-1:0] tgt,
                                  input logic [MeasW-1:0] meas,
                                  output bridge_result_t res);
        longint meas_signed;
        longint err;
        longint acc;
        longint drv;
        longint drv_mag;
        longint full;
        longint offs_eff;
        longint duty;
        int     res_bits;
        meas_signed = heading_fwd ? longint'(meas) : -longint'(meas);
        err = longint'(tgt) - meas_signed;

        // saturating integrator
        acc = integ_acc + err;
        if (acc > IntTop)
            acc = IntTop;
        if (acc < IntBottom)
            acc = IntBottom;
        integ_acc = acc;

        // pi sum in q1.16, clamped to +-1.0
        drv = err * longint'(kp) + integ_acc * longint'(ki);
        if (drv > longint'(pvh_pkg::DRIVE_ONE))
            drv = longint'(pvh_pkg::DRIVE_ONE);
        if (drv < -longint'(pvh_pkg::DRIVE_ONE))
            drv = -longint'(pvh_pkg::DRIVE_ONE);
        drv_mag = (drv < 0) ? -drv : drv;

        // duty scaling, resolution and offset clipped first
        res_bits = int'(pwm_res);
        if (res_bits < int'(pvh_pkg::PWM_BITS_MIN))
            res_bits = int'(pvh_pkg::PWM_BITS_MIN);
        if (res_bits > int'(pvh_pkg::PWM_BITS_MAX))
            res_bits = int'(pvh_pkg::PWM_BITS_MAX);
        full = longint'(1) << res_bits;
        offs_eff = (longint'(offset_reg) > full) ? full : longint'(offset_reg);
        duty = offs_eff + (((full - offs_eff) * drv_mag) >>> 16);

        res.fwd = '0;
        res.rev = '0;
        if (drv > 0)
        begin
            res.fwd = DutyW'(duty);
            heading_fwd = 1'b1;
        end
        else if (drv < 0)
        begin
            res.rev = DutyW'(duty);
            heading_fwd = 1'b0;
        end
        res.dir   = heading_fwd;
        res.err   = ErrW'(err);
        res.level = DutyW'(duty);
    endtask

    // register write; the predictor takes the new value at the handshake
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            pvh_pkg::REG_P_GAIN:   kp = data[GainW-1:0];
            pvh_pkg::REG_I_GAIN:   ki = data[GainW-1:0];
            pvh_pkg::REG_MIN_DUTY: offset_reg = data[DutyW-1:0];
            pvh_pkg::REG_PWM_BITS: pwm_res = data[BitsW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one input word; valid stays high into the next word when gap is 0
    task automatic send_tick(input logic signed [SpeedW-1:0] tgt, input logic [MeasW-1:0] meas,
                             input int gap, input bit typed_ok, input bridge_result_t typed);
        bridge_result_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid              <= 1'b0;
            in_ch.target_speed       <= SpeedW'($urandom);
            in_ch.measured_speed_abs <= MeasW'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.target_speed       <= tgt;
        in_ch.measured_speed_abs <= meas;
        do @(posedge clk); while (!in_ch.ready);
        predict_bridge(tgt, meas, predicted);
        pending_duties.push_back(typed_ok ? typed : predicted);
    endtask

    // drop valid and wait until every owed result word is back
    task automatic drain_words();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // mostly a wheel tracking its target, some small jitter, some full-range noise
    task automatic random_tick(input int gap);
        int                       shape;
        int                       t;
        int                       m;
        logic signed [SpeedW-1:0] tgt;
        logic [MeasW-1:0]         meas;
        shape = $urandom_range(0, 19);
        if (shape < 12)
        begin
            t = int'($urandom_range(0, 4000)) - 2000;
            m = ((t < 0) ? -t : t) + int'($urandom_range(0, 64)) - 32;
            if (m < 0)
                m = 0;
            tgt  = SpeedW'(t);
            meas = MeasW'(m);
        end
        else if (shape < 17)
        begin
            t    = int'($urandom_range(0, 600)) - 300;
            tgt  = SpeedW'(t);
            meas = MeasW'($urandom_range(0, 300));
        end
        else
        begin
            tgt  = SpeedW'($urandom);
            meas = MeasW'($urandom);
        end
        send_tick(tgt, meas, gap, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // result side: compare each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        bridge_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_duties.size() == 0)
            begin
                mismatch_count++;
                $error("result word with nothing expected");
            end
            else
            begin
                want = pending_duties.pop_front();
                check_field("duty_forward", int'(want.fwd), int'(out_ch.duty_forward));
                check_field("duty_reverse", int'(want.rev), int'(out_ch.duty_reverse));
                check_field("moving_forward", int'(want.dir), int'(out_ch.moving_forward));
                check_field("speed_error", int'(want.err), int'(out_ch.speed_error));
                check_field("duty_level", int'(want.level), int'(out_ch.duty_level));
            end
            stall_left = sink_stalls ? int'($urandom_range(0, 17)) : 0;
        end
    end

    // ready drops for the drawn number of cycles after each result word
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   = stall_left - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    initial begin
        int             sent;
        int             phase_len;
        int             pick;
        logic [CfgDataW-1:0] val;

        // every block input known from time zero
        rst_n                    = 1'b0;
        in_ch.valid              = 1'b0;
        in_ch.target_speed       = '0;
        in_ch.measured_speed_abs = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = pvh_pkg::REG_P_GAIN;
        cfg_ch.data              = '0;
        out_ch.ready             = 1'b0;
        stall_left               = 0;
        mismatch_count           = 0;
        sender_gaps              = 1'b1;
        sink_stalls              = 1'b1;

        // predictor at its reset state
        kp          = '0;
        ki          = '0;
        offset_reg  = '0;
        pwm_res     = pvh_pkg::PWM_BITS_RST;
        integ_acc   = 0;
        heading_fwd = 1'b1;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed table
        foreach (DirectedRows[r])
        begin
            case (DirectedRows[r].kind)
                ROW_CFG:
                begin
                    drain_words();
                    write_reg(DirectedRows[r].reg_idx, DirectedRows[r].reg_data);
                end
                ROW_TICK:
                    send_tick(DirectedRows[r].tgt, DirectedRows[r].meas,
                              $urandom_range(0, 17), 1'b0, '0);
                default:
                    send_tick(DirectedRows[r].tgt, DirectedRows[r].meas,
                              $urandom_range(0, 17), 1'b1, DirectedRows[r].want);
            endcase
        end

        // random phases, each with fresh register settings and idling style
        sent = 0;
        while (sent < RandomTicks)
        begin
            drain_words();

            pick = $urandom_range(0, 5);
            val = (pick == 0) ? 17'd0 :
                  (pick == 1) ? 17'd65535 :
                  (pick == 2) ? CfgDataW'($urandom_range(1, 8)) :
                  (pick == 3) ? CfgDataW'($urandom_range(9, 300)) :
                  CfgDataW'($urandom);
            write_reg(pvh_pkg::REG_P_GAIN, val);

            pick = $urandom_range(0, 5);
            val = (pick == 0) ? 17'd0 :
                  (pick == 1) ? 17'd65535 :
                  (pick == 2) ? CfgDataW'($urandom_range(1, 4)) :
                  (pick == 3) ? CfgDataW'($urandom_range(5, 64)) :
                  CfgDataW'($urandom);
            write_reg(pvh_pkg::REG_I_GAIN, val);

            pick = $urandom_range(0, 5);
            val = (pick == 0) ? 17'd0 :
                  (pick == 1) ? 17'd65536 :
                  (pick == 2) ? 17'h1FFFF :
                  (pick == 3) ? CfgDataW'($urandom_range(0, 300)) :
                  CfgDataW'($urandom);
            write_reg(pvh_pkg::REG_MIN_DUTY, val);

            // resolution anywhere in the 5-bit field, the legal limits favored,
            // upper data bits random since only the low five count
            pick = $urandom_range(0, 5);
            val = CfgDataW'($urandom) & ~CfgDataW'(5'h1F);
            val[BitsW-1:0] = (pick == 0) ? pvh_pkg::PWM_BITS_MIN :
                             (pick == 1) ? pvh_pkg::PWM_BITS_MAX :
                             BitsW'($urandom_range(0, 31));
            write_reg(pvh_pkg::REG_PWM_BITS, val);

            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            phase_len   = $urandom_range(30, 110);
            repeat (phase_len)
            begin
                // now and then the sender holds off until the block is empty
                if ($urandom_range(0, 49) == 0)
                    drain_words();
                random_tick(sender_gaps ? int'($urandom_range(0, 17)) : 0);
                sent++;
            end
        end

        // integral term alone at the largest gain, drive clamped by the
        // accumulated error while the result side stalls
        drain_words();
        write_reg(pvh_pkg::REG_P_GAIN, 17'd0);
        write_reg(pvh_pkg::REG_I_GAIN, 17'd65535);
        sink_stalls = 1'b1;
        repeat (3) send_tick(16'sd0, 15'd0, 0, 1'b0, '0);
        repeat (6) random_tick($urandom_range(0, 17));

        drain_words();
        if (pending_duties.size() != 0)
        begin
            mismatch_count++;
            $error("result words still owed: %0d", pending_duties.size());
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### pi_velocity_hbridge_pwm.f
sv/pvh_pkg.sv
sv/pvh_in_if.sv
sv/pvh_out_if.sv
sv/pvh_cfg_if.sv
sv/pvh_ctrl.sv
sv/pvh_datapath.sv
sv/pi_velocity_hbridge_pwm.sv
sv/pvh_checker.sv
bench/tb.sv
